[hdl/gtg_pkg.sv]
// gtg_pkg: types, codes, widths and helper functions of the go-to-goal controller
// no dependencies; used by gtg_cordic, gtg_datapath, gtg_ctrl and the top

package gtg_pkg;

    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int XY_W    = 37;
    localparam int Z_W     = 32;
    localparam int H_W     = 33;
    localparam int E_W     = 34;
    localparam int P_W     = 54;
    localparam int STEP_IW = 6;

    localparam logic [IDX_W-1:0] CFG_GOAL_X   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GOAL_Y   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_START_X  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_START_Y  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_HEAD_TOL = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ARR_TOL  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPD_GAIN = 3'd6;
    localparam logic [IDX_W-1:0] CFG_STR_GAIN = 3'd7;

    localparam logic [14:0] HEAD_TOL_RST = 15'd41;
    localparam logic [30:0] ARR_TOL_RST  = 31'd6554;
    localparam logic [15:0] SPD_GAIN_RST = 16'd2048;
    localparam logic [15:0] STR_GAIN_RST = 16'd16384;

    localparam logic signed [E_W-1:0] PI_Q      = 34'sd843314857;
    localparam logic signed [E_W-1:0] TWO_PI_Q  = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] HALF_PI_Q = 32'sd421657428;
    localparam logic signed [17:0]    MAG_SCALE = 18'sd39797;

    typedef enum logic [1:0] {
        PH_ROTATE    = 2'd0,
        PH_TRANSLATE = 2'd1,
        PH_ARRIVED   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SRC_HEAD  = 2'd0,
        SRC_START = 2'd1,
        SRC_POS   = 2'd2
    } t_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_START,
        S_HEAD_RUN,
        S_BEAR_START,
        S_BEAR_RUN,
        S_WRAP,
        S_DECIDE,
        S_LIN,
        S_TURN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic   load_in;
        logic   cordic_start;
        t_src   src;
        logic   save_heading;
        logic   save_bear;
        logic   wrap_step;
        logic   rot_turn;
        logic   clr_res;
        logic   mul_lin;
        logic   mul_turn;
        logic   load_out;
        t_phase res_phase;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_done;
        logic wrap_ok;
        logic head_ok;
        logic arrived;
    } t_dp_stat;

    function automatic logic signed [Z_W-1:0] angle_step(input logic [STEP_IW-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            6'd0: r = 32'sd210828714;
            6'd1: r = 32'sd124459457;
            6'd2: r = 32'sd65760959;
            6'd3: r = 32'sd33381290;
            6'd4: r = 32'sd16755422;
            6'd5: r = 32'sd8385879;
            6'd6: r = 32'sd4193963;
            6'd7: r = 32'sd2097109;
            6'd8: r = 32'sd1048571;
            6'd9: r = 32'sd524287;
            default: begin
                if (i <= 6'd28) begin
                    r = 32'sd1 <<< (6'd28 - i);
                end else begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] v);
        logic signed [31:0] r;
        if (v > 54'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -54'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/gtg_pose_if.sv]
// gtg_pose_if: pose item channel, valid/ready with position and yaw quaternion pair
// depends on nothing

interface gtg_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, pos_x, pos_y, quat_z, quat_w, input ready);
    modport sink   (input valid, pos_x, pos_y, quat_z, quat_w, output ready);
endinterface

[hdl/gtg_cmd_if.sv]
// gtg_cmd_if: motion command item channel, valid/ready with speeds and phase
// depends on nothing

interface gtg_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic [1:0]         phase;

    modport source (output valid, linear_speed, turn_rate, phase, input ready);
    modport sink   (input valid, linear_speed, turn_rate, phase, output ready);
endinterface

[hdl/gtg_cordic.sv]
// gtg_cordic: iterative vectoring cordic, one micro-rotation per cycle
// depends on gtg_pkg

module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    output logic                   o_done,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [Z_W-1:0]  o_z
);
    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic [IW-1:0]          r_i, n_i;
    logic                   r_busy, n_busy, r_done, n_done;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  step;

    always_comb begin
        dx   = r_y >>> r_i;
        dy   = r_x >>> r_i;
        step = angle_step(STEP_IW'(r_i));
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_i = r_i;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_i = '0;
            if (i_x == '0 && i_y == '0) begin
                n_x = '0;
                n_y = '0;
                n_z = '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_x = i_x;
                n_y = i_y;
                n_z = '0;
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        n_x = i_y;
                        n_y = -i_x;
                        n_z = HALF_PI_Q;
                    end else begin
                        n_x = -i_y;
                        n_y = i_x;
                        n_z = -HALF_PI_Q;
                    end
                end
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + step;
            end else begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - step;
            end
            if (r_i == IW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_i = r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i    <= n_i;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;
endmodule

[hdl/gtg_datapath.sv]
// gtg_datapath: config registers, pose latch, shared cordic, error wrap, multiplier, result
// depends on gtg_pkg and gtg_cordic

module gtg_datapath
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic signed [31:0] o_linear_speed,
    output logic signed [31:0] o_turn_rate,
    output logic [1:0]         o_phase
);
    logic signed [31:0]     r_goal_x, r_goal_y, r_start_x, r_start_y;
    logic [14:0]            r_head_tol;
    logic [30:0]            r_arr_tol;
    logic [15:0]            r_spd_gain, r_str_gain;
    logic signed [31:0]     r_px, r_py;
    logic signed [15:0]     r_qz, r_qw;
    logic signed [H_W-1:0]  r_heading;
    logic signed [E_W-1:0]  r_err;
    logic signed [XY_W-1:0] r_dist;
    logic signed [31:0]     r_lin, r_turn, r_o_lin, r_o_turn;
    logic [1:0]             r_o_phase;

    logic signed [XY_W-1:0] c_x, c_y, c_ox;
    logic signed [Z_W-1:0]  c_oz;
    logic                   c_done;
    logic signed [XY_W-1:0] mul_a;
    logic signed [17:0]     mul_b;
    logic signed [P_W-1:0]  prod, prod_mag, prod_lin, prod_turn;
    logic signed [E_W-1:0]  err_abs, rot_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x   <= '0;
            r_goal_y   <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_head_tol <= HEAD_TOL_RST;
            r_arr_tol  <= ARR_TOL_RST;
            r_spd_gain <= SPD_GAIN_RST;
            r_str_gain <= STR_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GOAL_X:   r_goal_x   <= i_cfg_data;
                CFG_GOAL_Y:   r_goal_y   <= i_cfg_data;
                CFG_START_X:  r_start_x  <= i_cfg_data;
                CFG_START_Y:  r_start_y  <= i_cfg_data;
                CFG_HEAD_TOL: r_head_tol <= i_cfg_data[14:0];
                CFG_ARR_TOL:  r_arr_tol  <= i_cfg_data[30:0];
                CFG_SPD_GAIN: r_spd_gain <= i_cfg_data[15:0];
                CFG_STR_GAIN: r_str_gain <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // cordic operand select
    always_comb begin
        case (i_cmd.src)
            SRC_START: begin
                c_x = XY_W'(33'(r_goal_x) - 33'(r_start_x));
                c_y = XY_W'(33'(r_goal_y) - 33'(r_start_y));
            end
            SRC_POS: begin
                c_x = XY_W'(33'(r_goal_x) - 33'(r_px));
                c_y = XY_W'(33'(r_goal_y) - 33'(r_py));
            end
            default: begin
                c_x = XY_W'($signed({r_qw, 16'h0000}));
                c_y = XY_W'($signed({r_qz, 16'h0000}));
            end
        endcase
    end

    gtg_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.cordic_start),
        .i_x    (c_x),
        .i_y    (c_y),
        .o_done (c_done),
        .o_x    (c_ox),
        .o_z    (c_oz)
    );

    // shared multiplier
    always_comb begin
        if (i_cmd.save_bear) begin
            mul_a = c_ox;
            mul_b = MAG_SCALE;
        end else if (i_cmd.mul_lin) begin
            mul_a = r_dist;
            mul_b = 18'(r_spd_gain);
        end else begin
            mul_a = XY_W'(r_err);
            mul_b = 18'(r_str_gain);
        end
        prod      = P_W'(mul_a) * P_W'(mul_b);
        prod_mag  = (prod + 54'sd32768) >>> 16;
        prod_lin  = (prod + 54'sd2048) >>> 12;
        prod_turn = (prod + 54'sd8388608) >>> 24;
        err_abs   = (r_err < 0) ? -r_err : r_err;
        rot_sum   = (r_err + 34'sd2048) >>> 12;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_qz <= i_quat_z;
            r_qw <= i_quat_w;
        end
        if (i_cmd.save_heading) begin
            r_heading <= {c_oz, 1'b0};
        end
        if (i_cmd.save_bear) begin
            r_err  <= E_W'(c_oz) - E_W'(r_heading);
            r_dist <= prod_mag[XY_W-1:0];
        end else if (i_cmd.wrap_step) begin
            r_err <= (r_err > PI_Q) ? r_err - TWO_PI_Q : r_err + TWO_PI_Q;
        end
        if (i_cmd.clr_res) begin
            r_lin  <= '0;
            r_turn <= '0;
        end else if (i_cmd.rot_turn) begin
            r_lin  <= '0;
            r_turn <= rot_sum[31:0];
        end
        if (i_cmd.mul_lin) begin
            r_lin <= sat32(prod_lin);
        end
        if (i_cmd.mul_turn) begin
            r_turn <= sat32(prod_turn);
        end
        if (i_cmd.load_out) begin
            r_o_lin   <= r_lin;
            r_o_turn  <= r_turn;
            r_o_phase <= i_cmd.res_phase;
        end
    end

    assign o_stat.cordic_done = c_done;
    assign o_stat.wrap_ok     = !(r_err > PI_Q) && !(r_err <= -PI_Q);
    assign o_stat.head_ok     = err_abs <= E_W'({r_head_tol, 16'h0000});
    assign o_stat.arrived     = r_dist <= XY_W'(r_arr_tol);

    assign o_linear_speed = r_o_lin;
    assign o_turn_rate    = r_o_turn;
    assign o_phase        = r_o_phase;
endmodule

[hdl/gtg_ctrl.sv]
// gtg_ctrl: sequencer and motion phase register, drives the datapath and both handshakes
// depends on gtg_pkg

module gtg_ctrl
    import gtg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_phase r_res, n_res;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ROTATE;
            r_res       <= PH_ROTATE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.src = SRC_HEAD;
        o_cmd.res_phase = r_res;
        o_in_ready = 1'b0;
        n_out_valid = (r_out_valid && !i_out_ready) ? 1'b1 : 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_HEAD_START;
                end
            end
            S_HEAD_START: begin
                o_cmd.cordic_start = 1'b1;
                n_state = S_HEAD_RUN;
            end
            S_HEAD_RUN: begin
                if (i_stat.cordic_done) begin
                    o_cmd.save_heading = 1'b1;
                    case (r_phase) inside
                        PH_ROTATE, PH_TRANSLATE: n_state = S_BEAR_START;
                        default: begin
                            o_cmd.clr_res = 1'b1;
                            n_res = PH_ARRIVED;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_BEAR_START: begin
                o_cmd.cordic_start = 1'b1;
                o_cmd.src = (r_phase == PH_ROTATE) ? SRC_START : SRC_POS;
                n_state = S_BEAR_RUN;
            end
            S_BEAR_RUN: begin
                if (i_stat.cordic_done) begin
                    o_cmd.save_bear = 1'b1;
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (i_stat.wrap_ok) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.wrap_step = 1'b1;
                end
            end
            S_DECIDE: begin
                if (r_phase == PH_ROTATE) begin
                    n_state = S_OUT;
                    if (i_stat.head_ok) begin
                        o_cmd.clr_res = 1'b1;
                        n_phase = PH_TRANSLATE;
                        n_res = PH_TRANSLATE;
                    end else begin
                        o_cmd.rot_turn = 1'b1;
                        n_res = PH_ROTATE;
                    end
                end else if (i_stat.arrived) begin
                    o_cmd.clr_res = 1'b1;
                    n_phase = PH_ARRIVED;
                    n_res = PH_ARRIVED;
                    n_state = S_OUT;
                end else begin
                    n_state = S_LIN;
                end
            end
            S_LIN: begin
                o_cmd.mul_lin = 1'b1;
                n_state = S_TURN;
            end
            S_TURN: begin
                o_cmd.mul_turn = 1'b1;
                n_res = PH_TRANSLATE;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

[hdl/go_to_goal_controller_top.sv]
// go_to_goal_controller_top: go-to-goal controller, one motion command item per pose item
// depends on gtg_pkg, gtg_pose_if, gtg_cmd_if, gtg_ctrl and gtg_datapath

// Each pose item yields exactly one command item. One shared vectoring CORDIC unit
// runs twice per item (heading from the quaternion pair, then bearing and distance),
// one micro-rotation per cycle; once arrived it runs only for the heading. The angle
// error is then wrapped in steps of two pi into (-pi, pi], and while translating the
// shared multiplier forms the linear speed, then the turn rate.
// A finished command sits in an output register, and the next pose item is taken
// while it waits. Config writes change no phase; only reset restarts rotation.

module go_to_goal_controller_top
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    gtg_pose_if.sink         i_pose,
    gtg_cmd_if.source        o_cmd
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    gtg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pose.valid),
        .o_in_ready (i_pose.ready),
        .o_out_valid(o_cmd.valid),
        .i_out_ready(o_cmd.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gtg_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pose.pos_x),
        .i_pos_y       (i_pose.pos_y),
        .i_quat_z      (i_pose.quat_z),
        .i_quat_w      (i_pose.quat_w),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_linear_speed(o_cmd.linear_speed),
        .o_turn_rate   (o_cmd.turn_rate),
        .o_phase       (o_cmd.phase)
    );
endmodule
